// ===== rtl/aud_mix_pkg.sv =====
// ============================================================================
// aud_mix_pkg
// Shared widths, register indexes, delay-line constants and saturation
// helpers for the stream mixer with feedback delay-line reverb.
// ============================================================================
package aud_mix_pkg;

	// sample and accumulator widths
	localparam int SAMPLE_BITS   = 16;
	localparam int EXTRA_BITS    = 4;
	localparam int ACC_BITS      = SAMPLE_BITS + EXTRA_BITS;
	localparam int TAP_SUM_BITS  = ACC_BITS + 5;
	localparam int TAP_SHIFT     = 3;
	localparam int S_BITS        = 24;
	localparam int BAL_BITS      = SAMPLE_BITS + 1;

	// channels, streams and delay lines
	localparam int MAX_CHANNELS  = 2;
	localparam int MAX_STREAMS   = 8;
	localparam int DELAY_LINES   = 7;
	localparam int LINE_TOTAL    = 35111;
	localparam int MEM_DEPTH     = MAX_CHANNELS * LINE_TOTAL;
	localparam int ADDR_BITS     = $clog2(MEM_DEPTH);
	localparam int PTR_BITS      = 14;
	localparam int CHAN_BITS     = $clog2(MAX_CHANNELS);
	localparam int LINE_BITS     = $clog2(DELAY_LINES);
	localparam int LIDX_BITS     = $clog2(MAX_CHANNELS * DELAY_LINES);
	localparam int CNT_BITS      = 4;

	// shared multiplier and shifts
	localparam int MUL_BITS      = 25;
	localparam int RECIP_BITS    = 24;
	localparam int RECIP_SHIFT   = 23;
	localparam int VOL_SHIFT     = 14;
	localparam int BAL_SHIFT     = 15;
	localparam logic signed [BAL_BITS-1:0] BAL_ONE = 17'sh08000;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STREAM_COUNT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME_GAIN   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BALANCE       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REVERB_ENABLE = 3'd4;

	// ring length of each delay line
	function automatic logic [PTR_BITS-1:0] line_len(input logic [LINE_BITS-1:0] n);
		logic [PTR_BITS-1:0] len;
		case (n)
			3'd0:    len = 14'd1229;
			3'd1:    len = 14'd1559;
			3'd2:    len = 14'd1907;
			3'd3:    len = 14'd4057;
			3'd4:    len = 14'd8117;
			3'd5:    len = 14'd8311;
			3'd6:    len = 14'd9931;
			default: len = 14'd1229;
		endcase
		return len;
	endfunction

	// start of each delay line within one channel's region
	function automatic logic [ADDR_BITS-1:0] line_base(input logic [LINE_BITS-1:0] n);
		logic [ADDR_BITS-1:0] base;
		case (n)
			3'd0:    base = 17'd0;
			3'd1:    base = 17'd1229;
			3'd2:    base = 17'd2788;
			3'd3:    base = 17'd4695;
			3'd4:    base = 17'd8752;
			3'd5:    base = 17'd16869;
			3'd6:    base = 17'd25180;
			default: base = 17'd0;
		endcase
		return base;
	endfunction

	// ceil(2^23 / d), exact floor quotient for magnitudes below 2^20
	function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] d);
		logic [RECIP_BITS-1:0] r;
		case (d)
			4'd2:    r = 24'd4194304;
			4'd3:    r = 24'd2796203;
			4'd4:    r = 24'd2097152;
			4'd5:    r = 24'd1677722;
			4'd6:    r = 24'd1398102;
			4'd7:    r = 24'd1198373;
			4'd8:    r = 24'd1048576;
			default: r = 24'd8388608;
		endcase
		return r;
	endfunction

	// saturate a grown accumulator sum back to the accumulator width
	function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS:0] v);
		logic signed [ACC_BITS-1:0] r;
		if (v[ACC_BITS] != v[ACC_BITS-1])
			r = v[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
		else
			r = v[ACC_BITS-1:0];
		return r;
	endfunction

	// saturate the shifted tap sum to the delay entry width
	function automatic logic signed [ACC_BITS-1:0] sat_y(
		input logic signed [TAP_SUM_BITS-1:0] t
	);
		logic [TAP_SUM_BITS-ACC_BITS:0] top;
		logic signed [ACC_BITS-1:0] r;
		top = t[TAP_SUM_BITS-1:ACC_BITS-1];
		if ((&top) || !(|top))
			r = t[ACC_BITS-1:0];
		else
			r = t[TAP_SUM_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
			                      : {1'b0, {(ACC_BITS-1){1'b1}}};
		return r;
	endfunction

	// saturate a scaled channel value to the sample width
	function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [S_BITS-1:0] s);
		logic [S_BITS-SAMPLE_BITS:0] top;
		logic signed [SAMPLE_BITS-1:0] r;
		top = s[S_BITS-1:SAMPLE_BITS-1];
		if ((&top) || !(|top))
			r = s[SAMPLE_BITS-1:0];
		else
			r = s[S_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		return r;
	endfunction

endpackage

// ===== rtl/audio_mixer_with_reverb.sv =====
// throughput: requests that do not close a frame are taken back to back; the frame work
// is set by one shared multiplier and 7 reads plus 7 writes per channel on a one-port memory
// reset: registers take their defaults at once; no clearing pass, a delay ring reads as
// zero until it has wrapped for the first time
// ============================================================================
// audio_mixer_with_reverb
// Sums stream frames, divides by the stream count, applies the optional
// seven-line feedback reverb, master volume and balance, and saturates.
// ============================================================================
module audio_mixer_with_reverb
	import aud_mix_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   first_sample,
	input  logic signed [SAMPLE_BITS-1:0]   second_sample,
	input  logic                            stream_is_mono,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_BITS-1:0]   left_out,
	output logic signed [SAMPLE_BITS-1:0]   right_out
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_QUOT, S_RD, S_SUM, S_Y, S_WR,
		S_VOL, S_SCL, S_BAL, S_BALR, S_OUT
	} state_t;

	// configuration registers
	logic [1:0]                     chan_cnt_q;
	logic [CNT_BITS-1:0]            strm_cnt_q;
	logic [15:0]                    vol_q;
	logic signed [15:0]             bal_q;
	logic                           rvb_en_q;

	// control state
	state_t                         state_q;
	logic signed [ACC_BITS-1:0]     acc_q [MAX_CHANNELS];
	logic [CNT_BITS-1:0]            sr_q;
	logic [CHAN_BITS-1:0]           chan_q;
	logic [LINE_BITS-1:0]           line_q;
	logic [PTR_BITS-1:0]            ptr_q [MAX_CHANNELS*DELAY_LINES];
	logic [MAX_CHANNELS*DELAY_LINES-1:0] fill_q;
	logic                           tap_vld_s1;
	logic                           out_valid_q;
	logic signed [SAMPLE_BITS-1:0]  left_q;
	logic signed [SAMPLE_BITS-1:0]  right_q;

	// datapath registers
	logic signed [2*MUL_BITS-1:0]   prod_q;
	logic                           neg_q;
	logic signed [ACC_BITS-1:0]     v_q;
	logic signed [ACC_BITS-1:0]     y_q;
	logic signed [TAP_SUM_BITS-1:0] sum_q;
	logic signed [S_BITS-1:0]       s_q [MAX_CHANNELS];
	logic                           tap_ok_s1;
	logic signed [ACC_BITS-1:0]     mem_rd_s1;
	logic signed [ACC_BITS-1:0]     delay_mem [MEM_DEPTH];

	// combinational signals
	logic                           in_acc;
	logic                           chans_two;
	logic [CNT_BITS-1:0]            cnt_eff;
	logic [CNT_BITS-1:0]            sr_next;
	logic                           frame_done;
	logic signed [SAMPLE_BITS-1:0]  samp_b;
	logic signed [ACC_BITS-1:0]     acc_new0;
	logic signed [ACC_BITS-1:0]     acc_new1;
	logic signed [ACC_BITS-1:0]     acc_cur;
	logic [ACC_BITS-1:0]            acc_mag;
	logic signed [ACC_BITS-1:0]     quot_mag;
	logic signed [ACC_BITS-1:0]     quot_v;
	logic                           bal_sel;
	logic signed [BAL_BITS-1:0]     bal_ext;
	logic signed [BAL_BITS-1:0]     bal_fac;
	logic signed [MUL_BITS-1:0]     mul_a;
	logic signed [MUL_BITS-1:0]     mul_b;
	logic [LIDX_BITS-1:0]           lidx;
	logic [PTR_BITS-1:0]            ptr_cur;
	logic [PTR_BITS-1:0]            ptr_inc;
	logic [PTR_BITS-1:0]            cur_len;
	logic [ADDR_BITS-1:0]           addr;
	logic                           last_line;
	logic                           out_load;
	logic signed [TAP_SUM_BITS-1:0] tap_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;

	// effective channel and stream counts
	assign chans_two = chan_cnt_q[1];
	always_comb begin
		if (strm_cnt_q == '0)
			cnt_eff = CNT_BITS'(1);
		else if (strm_cnt_q > CNT_BITS'(MAX_STREAMS))
			cnt_eff = CNT_BITS'(MAX_STREAMS);
		else
			cnt_eff = strm_cnt_q;
	end

	// frame accumulation on each request
	assign samp_b     = stream_is_mono ? first_sample : second_sample;
	assign acc_new0   = sat_acc({acc_q[0][ACC_BITS-1], acc_q[0]}
	                    + {{(ACC_BITS+1-SAMPLE_BITS){first_sample[SAMPLE_BITS-1]}}, first_sample});
	assign acc_new1   = sat_acc({acc_q[1][ACC_BITS-1], acc_q[1]}
	                    + {{(ACC_BITS+1-SAMPLE_BITS){samp_b[SAMPLE_BITS-1]}}, samp_b});
	assign sr_next    = sr_q + CNT_BITS'(1);
	assign frame_done = (sr_next >= cnt_eff);

	// magnitude and signed quotient of the channel sum
	assign acc_cur  = acc_q[chan_q];
	assign acc_mag  = acc_cur[ACC_BITS-1] ? (~acc_cur + ACC_BITS'(1)) : acc_cur;
	assign quot_mag = prod_q[RECIP_SHIFT +: ACC_BITS];
	assign quot_v   = neg_q ? -quot_mag : quot_mag;

	// balance factor and the side it scales
	assign bal_sel = bal_q[15];
	assign bal_ext = {bal_q[15], bal_q};
	assign bal_fac = bal_sel ? (BAL_ONE + bal_ext) : (BAL_ONE - bal_ext);

	// shared multiplier operand selection
	always_comb begin
		case (state_q)
			S_DIV: begin
				mul_a = {{(MUL_BITS-ACC_BITS){1'b0}}, acc_mag};
				mul_b = {{(MUL_BITS-RECIP_BITS){1'b0}}, recip(cnt_eff)};
			end
			S_VOL: begin
				mul_a = {{(MUL_BITS-ACC_BITS){v_q[ACC_BITS-1]}}, v_q};
				mul_b = {{(MUL_BITS-16){1'b0}}, vol_q};
			end
			S_BAL: begin
				mul_a = {{(MUL_BITS-S_BITS){s_q[bal_sel][S_BITS-1]}}, s_q[bal_sel]};
				mul_b = {{(MUL_BITS-BAL_BITS){1'b0}}, bal_fac};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// delay ring addressing
	assign lidx      = LIDX_BITS'(chan_q) * LIDX_BITS'(DELAY_LINES) + LIDX_BITS'(line_q);
	assign ptr_cur   = ptr_q[lidx];
	assign cur_len   = line_len(line_q);
	assign ptr_inc   = ptr_cur + PTR_BITS'(1);
	assign addr      = ADDR_BITS'(chan_q) * ADDR_BITS'(LINE_TOTAL) + line_base(line_q)
	                   + ADDR_BITS'(ptr_cur);
	assign last_line = (line_q == LINE_BITS'(DELAY_LINES-1));
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign tap_ext   = tap_ok_s1
	                   ? {{(TAP_SUM_BITS-ACC_BITS){mem_rd_s1[ACC_BITS-1]}}, mem_rd_s1}
	                   : '0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= 2'd2;
			strm_cnt_q <= CNT_BITS'(1);
			vol_q      <= 16'd16384;
			bal_q      <= '0;
			rvb_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[1:0];
				REG_STREAM_COUNT:  strm_cnt_q <= cfg_data[CNT_BITS-1:0];
				REG_VOLUME_GAIN:   vol_q      <= cfg_data;
				REG_BALANCE:       bal_q      <= cfg_data;
				REG_REVERB_ENABLE: rvb_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, ring pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			sr_q        <= '0;
			chan_q      <= '0;
			line_q      <= '0;
			for (int i = 0; i < MAX_CHANNELS*DELAY_LINES; i++)
				ptr_q[i] <= '0;
			fill_q      <= '0;
			tap_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
		end else begin
			tap_vld_s1 <= (state_q == S_RD);
			// result valid: set on a load, cleared once taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						acc_q[0] <= acc_new0;
						acc_q[1] <= acc_new1;
						sr_q     <= sr_next;
						chan_q   <= '0;
						if (frame_done)
							state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_QUOT;
				S_QUOT: begin
					line_q  <= '0;
					state_q <= rvb_en_q ? S_RD : S_VOL;
				end
				S_RD: begin
					if (last_line) begin
						line_q  <= '0;
						state_q <= S_SUM;
					end else begin
						line_q <= line_q + LINE_BITS'(1);
					end
				end
				S_SUM: state_q <= S_Y;
				S_Y:   state_q <= S_WR;
				S_WR: begin
					if (ptr_inc == cur_len) begin
						ptr_q[lidx]  <= '0;
						fill_q[lidx] <= 1'b1;
					end else begin
						ptr_q[lidx] <= ptr_inc;
					end
					if (last_line) begin
						line_q  <= '0;
						state_q <= S_VOL;
					end else begin
						line_q <= line_q + LINE_BITS'(1);
					end
				end
				S_VOL: state_q <= S_SCL;
				S_SCL: begin
					if (chan_q == '0 && chans_two) begin
						chan_q  <= CHAN_BITS'(1);
						state_q <= S_DIV;
					end else if (chans_two && bal_q != '0) begin
						state_q <= S_BAL;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_BAL:  state_q <= S_BALR;
				S_BALR: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						left_q      <= sat_out(s_q[0]);
						right_q     <= sat_out(s_q[1]);
						acc_q[0]    <= '0;
						acc_q[1]    <= '0;
						sr_q        <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// arithmetic datapath around the shared multiplier
	always_ff @(posedge clk) begin
		prod_q    <= mul_a * mul_b;
		tap_ok_s1 <= fill_q[lidx];
		if (tap_vld_s1)
			sum_q <= sum_q + tap_ext;
		case (state_q)
			S_IDLE: begin
				if (in_acc && frame_done) begin
					s_q[0] <= '0;
					s_q[1] <= '0;
				end
			end
			S_DIV: neg_q <= acc_cur[ACC_BITS-1];
			S_QUOT: begin
				v_q   <= quot_v;
				sum_q <= {{(TAP_SUM_BITS-ACC_BITS-EXTRA_BITS){quot_v[ACC_BITS-1]}},
				          quot_v, {EXTRA_BITS{1'b0}}};
			end
			S_Y: y_q <= sat_y(sum_q >>> TAP_SHIFT);
			S_WR: begin
				if (last_line)
					v_q <= {y_q[ACC_BITS-1], y_q[ACC_BITS-1:1]};
			end
			S_SCL:  s_q[chan_q]  <= prod_q[VOL_SHIFT +: S_BITS];
			S_BALR: s_q[bal_sel] <= prod_q[BAL_SHIFT +: S_BITS];
			default: ;
		endcase
	end

	// delay memory, one port, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_WR)
			delay_mem[addr] <= y_q;
		mem_rd_s1 <= delay_mem[addr];
	end

`ifndef SYNTH
	// frame counter never passes the largest stream count
	assert property (@(posedge clk) disable iff (!arst_n)
		sr_q <= CNT_BITS'(MAX_STREAMS))
		else $error("stream counter beyond maximum");

	// ring pointer stays inside its line while the memory is in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_WR) |-> (ptr_cur < cur_len))
		else $error("delay pointer outside its line");

	// loading a result frees the input and restarts the frame count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && sr_q == '0 && in_ready))
		else $error("result load did not restart the frame");
`endif

endmodule

// ===== tb/audio_mixer_with_reverb_tb.sv =====
// ============================================================================
// audio_mixer_with_reverb_tb
// Self-checking bench for the stream mixer: frames go in through a
// valid/ready request channel with random gaps, results come out against
// random back-pressure, and a scoreboard with its own copy of the mix,
// reverb rings, volume and balance arithmetic checks every output frame.
// ============================================================================
module audio_mixer_with_reverb_tb
	import aud_mix_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 64;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SHOWN_ERRORS  = 10;
	localparam int SOAK_QUIET    = 250;
	localparam int SOAK_BUSY     = 300;
	localparam int MIX_PHASES    = 10;
	localparam int PHASE_FRAMES  = 35;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} mix_out_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     cfg_valid      = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index      = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data       = '0;
	logic                     in_valid       = 1'b0;
	logic                     in_ready;
	sample_t                  first_sample   = '0;
	sample_t                  second_sample  = '0;
	logic                     stream_is_mono = 1'b0;
	logic                     out_valid;
	logic                     out_ready      = 1'b0;
	sample_t                  left_out;
	sample_t                  right_out;

	bit          gaps_on   = 1'b0;
	bit          stalls_on = 1'b0;
	int unsigned reg_writes = 0;
	int unsigned quiet_cycles = 0;

	audio_mixer_with_reverb i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_sample   (first_sample),
		.second_sample  (second_sample),
		.stream_is_mono (stream_is_mono),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_out       (left_out),
		.right_out      (right_out)
	);

	// length of each reverb ring
	function automatic int delay_len(input int n);
		case (n)
			0:       return 1229;
			1:       return 1559;
			2:       return 1907;
			3:       return 4057;
			4:       return 8117;
			5:       return 8311;
			default: return 9931;
		endcase
	endfunction

	// offset of a ring inside one channel's block of taps
	function automatic int delay_start(input int n);
		int k;
		int at;
		at = 0;
		for (k = 0; k < n; k++)
			at += delay_len(k);
		return at;
	endfunction

	// expected output frames and the block's mirrored state
	class mix_scoreboard;
		int       ch_reg;
		int       streams_reg;
		int       gain_reg;
		int       bal_reg;
		bit       reverb_on;
		longint   mix_sum [MAX_CHANNELS];
		int       frames_in;
		int       taps [MAX_CHANNELS*LINE_TOTAL];
		int       tap_pos [MAX_CHANNELS][DELAY_LINES];
		mix_out_t expected_q [$];
		int       mismatches;
		int       results_checked;
		int       frames_noted;
		int       reverb_frames;

		function new();
			ch_reg          = 2;
			streams_reg     = 1;
			gain_reg        = 16384;
			bal_reg         = 0;
			reverb_on       = 1'b0;
			mix_sum[0]      = 0;
			mix_sum[1]      = 0;
			frames_in       = 0;
			mismatches      = 0;
			results_checked = 0;
			frames_noted    = 0;
			reverb_frames   = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint clip(input longint v, input int w);
			longint hi;
			longint lo;
			hi = (longint'(1) << (w - 1)) - 1;
			lo = -hi - 1;
			return (v > hi) ? hi : ((v < lo) ? lo : v);
		endfunction

		// register write as seen on the config channel
		function void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
		                        input logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_CHANNEL_COUNT: ch_reg      = data[1:0];
				REG_STREAM_COUNT:  streams_reg = data[3:0];
				REG_VOLUME_GAIN:   gain_reg    = data;
				REG_BALANCE:       bal_reg     = $signed(data);
				REG_REVERB_ENABLE: reverb_on   = data[0];
				default: ;
			endcase
		endfunction

		// one pass through the seven feedback rings of a channel
		function longint reverb_tap(input int c, input longint x);
			longint sum;
			longint y;
			int     n;
			int     at;
			sum = x * 16;
			for (n = 0; n < DELAY_LINES; n++) begin
				at = c * LINE_TOTAL + delay_start(n) + tap_pos[c][n];
				sum += taps[at];
			end
			y = clip(sum >>> 3, ACC_BITS);
			for (n = 0; n < DELAY_LINES; n++) begin
				at = c * LINE_TOTAL + delay_start(n) + tap_pos[c][n];
				taps[at] = int'(y);
				tap_pos[c][n] = (tap_pos[c][n] + 1 >= delay_len(n)) ? 0 : tap_pos[c][n] + 1;
			end
			return y >>> 1;
		endfunction

		// accepted input frame: accumulate, and close the output frame when due
		function void note_frame(input sample_t l, input sample_t r, input logic mono);
			longint   feed [MAX_CHANNELS];
			longint   s [MAX_CHANNELS];
			longint   v;
			int       chans;
			int       count;
			int       c;
			mix_out_t res;
			frames_noted++;
			feed[0] = l;
			feed[1] = mono ? l : r;
			chans = (ch_reg == 0) ? 1 : ((ch_reg > MAX_CHANNELS) ? MAX_CHANNELS : ch_reg);
			count = (streams_reg == 0) ? 1 :
			        ((streams_reg > MAX_STREAMS) ? MAX_STREAMS : streams_reg);
			mix_sum[0] = clip(mix_sum[0] + feed[0], ACC_BITS);
			mix_sum[1] = clip(mix_sum[1] + feed[1], ACC_BITS);
			frames_in = (frames_in + 1) & 15;
			if (frames_in < count)
				return;
			s[0] = 0;
			s[1] = 0;
			if (reverb_on)
				reverb_frames++;
			for (c = 0; c < chans; c++) begin
				v = mix_sum[c] / count;
				if (reverb_on)
					v = reverb_tap(c, v);
				s[c] = (v * gain_reg) >>> VOL_SHIFT;
			end
			// balance only with a stereo output
			if (chans == 2) begin
				if (bal_reg < 0)
					s[1] = (s[1] * (32768 + bal_reg)) >>> BAL_SHIFT;
				if (bal_reg > 0)
					s[0] = (s[0] * (32768 - bal_reg)) >>> BAL_SHIFT;
			end
			mix_sum[0] = 0;
			mix_sum[1] = 0;
			frames_in  = 0;
			res.left   = sample_t'(clip(s[0], SAMPLE_BITS));
			res.right  = sample_t'(clip(s[1], SAMPLE_BITS));
			expected_q.push_back(res);
		endfunction

		function void flag(input string what, input longint want, input longint got);
			mismatches++;
			if (mismatches <= SHOWN_ERRORS)
				$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		endfunction

		// output frame from the block against the oldest expected one
		function void check_output(input sample_t l, input sample_t r);
			mix_out_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("%0t unexpected output frame: left %0d right %0d", $realtime, l, r);
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (l !== want.left)
				flag("left_out", want.left, l);
			if (r !== want.right)
				flag("right_out", want.right, r);
		endfunction
	endclass

	mix_scoreboard book = new();

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// watch the request channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			book.note_frame(first_sample, second_sample, stream_is_mono);
		if (arst_n && cfg_valid && cfg_ready) begin
			book.apply_reg(cfg_index, cfg_data);
			reg_writes++;
		end
	end

	// output side: check results and apply back-pressure
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_output(left_out, right_out);
		out_ready <= !(stalls_on && $urandom_range(99) < 12);
	end

	// watchdog on cycles with no request moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// sample with a bias towards full scale and the values around zero
	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0:       return sample_t'(16'h7FFF);
			1:       return sample_t'(16'h8000);
			2:       return sample_t'(int'($urandom_range(2)) - 1);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// one input frame; valid stays high into the next frame unless a gap is taken
	task automatic send_frame(input sample_t l, input sample_t r, input logic mono);
		int unsigned gap;
		gap = 0;
		while (gaps_on && $urandom_range(99) < 12)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		first_sample   <= l;
		second_sample  <= r;
		stream_is_mono <= mono;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_frame(pick_sample(), pick_sample(), 1'($urandom_range(1)));
	endtask

	task automatic post_reg(input logic [CFG_IDX_BITS-1:0] idx,
	                        input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full register set, written in index order
	task automatic program_regs(input logic [15:0] ch, input logic [15:0] sc,
	                            input logic [15:0] vol, input logic [15:0] bal,
	                            input logic [15:0] rev);
		post_reg(REG_CHANNEL_COUNT, ch);
		post_reg(REG_STREAM_COUNT, sc);
		post_reg(REG_VOLUME_GAIN, vol);
		post_reg(REG_BALANCE, bal);
		post_reg(REG_REVERB_ENABLE, rev);
		cfg_valid <= 1'b0;
	endtask

	// drain all expected results, then give the block time to finish a silent frame
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random register set for one mixing phase, extremes weighted in
	task automatic random_regs();
		logic [15:0] ch;
		logic [15:0] sc;
		logic [15:0] vol;
		logic [15:0] bal;
		ch = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
		sc = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4));
		case ($urandom_range(4))
			0:       vol = 16'h0000;
			1:       vol = 16'hFFFF;
			2:       vol = 16'h4000;
			default: vol = 16'($urandom);
		endcase
		case ($urandom_range(4))
			0:       bal = 16'h8000;
			1:       bal = 16'h7FFF;
			2:       bal = 16'h0000;
			default: bal = 16'($urandom);
		endcase
		program_regs(ch, sc, vol, bal, 16'($urandom));
	endtask

	initial begin
		int ph;
		int i;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: stereo, one stream, unity volume, centred, no reverb
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0);
		send_frame(16'sh0000, 16'sh0000, 1'b0);
		send_frame(-16'sd1, 16'sd1, 1'b0);
		send_frame(16'sh8000, 16'sh1234, 1'b1);

		// mono output with upper data bits set, stream count zero, full volume, hard left
		wait_idle();
		program_regs(16'hFFFD, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0);
		send_frame(16'sd1, -16'sd1, 1'b1);

		// over-range channel and stream counts, hard right; writes beyond the map ignored
		wait_idle();
		for (i = REG_REVERB_ENABLE + 1; i < (1 << CFG_IDX_BITS); i++)
			post_reg(CFG_IDX_BITS'(i), 16'hFFFF);
		program_regs(16'h0003, 16'h000F, 16'h4000, 16'h7FFF, 16'h0000);
		for (i = 0; i < 8; i++)
			send_frame(16'sh7FFF, 16'sh8000, i[0]);

		// stream count lowered part way through a frame
		wait_idle();
		program_regs(16'h0002, 16'h0004, 16'h4000, 16'h8000, 16'h0000);
		send_frame(16'sh7FFF, -16'sd7, 1'b0);
		send_frame(16'sh6000, 16'sh8000, 1'b0);
		send_frame(-16'sd3, 16'sh1000, 1'b1);
		wait_idle();
		program_regs(16'h0002, 16'h0002, 16'h4000, 16'h8000, 16'h0000);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);

		// reverb at zero and at full volume
		wait_idle();
		program_regs(16'h0002, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0);
		wait_idle();
		program_regs(16'h0002, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh0000, 1'b1);

		// long stereo reverb run; first part without idling
		wait_idle();
		program_regs(16'h0002, 16'h0001, 16'($urandom_range(8192, 32768)),
		             16'($urandom_range(0, 8192) - 4096), 16'h0001);
		send_random(SOAK_QUIET);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		send_random(SOAK_BUSY);

		// mixing phases with random settings
		for (ph = 0; ph < MIX_PHASES; ph++) begin
			wait_idle();
			random_regs();
			gaps_on   = ($urandom_range(4) != 0);
			stalls_on = ($urandom_range(4) != 0);
			send_random(PHASE_FRAMES);
		end

		wait_idle();
		$display("%0d frames sent, %0d output frames checked, %0d register writes",
		         book.frames_noted, book.results_checked, reg_writes);
		$display("%0d output frames went through the reverb rings", book.reverb_frames);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
